@@ design/rgb_to_hsv_byte_defines.svh @@
// Assertion macros used by the checker file.
`ifndef RGB_TO_HSV_BYTE_DEFINES_SVH
`define RGB_TO_HSV_BYTE_DEFINES_SVH

// When cond holds at an edge outside reset, prop must hold at the same edge.
`define RHSV_ASSERT_SAME(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("rgb_to_hsv_byte check failed");

// When cond holds at an edge, prop must hold at the next edge.
`define RHSV_ASSERT_NEXT(label, clk, cond, prop) \
  label: assert property (@(posedge clk) (cond) |=> (prop)) \
    else $error("rgb_to_hsv_byte check failed");

`endif

@@ design/rhsv_pkg.sv @@
package rhsv_pkg;

  localparam logic [15:0] SAT_SCALE  = 16'd255;
  localparam logic [15:0] HUE_STEP   = 16'd43;
  localparam logic [7:0]  BASE_RED   = 8'd0;
  localparam logic [7:0]  BASE_GREEN = 8'd85;
  localparam logic [7:0]  BASE_BLUE  = 8'd171;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int DIV_STAGES = 8;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_t;

  // Classified pixel handed from the front to the back through the queue.
  typedef struct packed {
    logic        grey;
    logic        neg;
    logic [7:0]  base;
    logic [7:0]  chroma;
    logic [7:0]  brightness;
    logic [15:0] sat_num;
    logic [15:0] hue_num;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // One lane of a restoring divider: partial remainder, dividend bits still
  // to be shifted in, and quotient bits gathered so far.
  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] low;
    logic [7:0] quo;
  } lane_t;

  typedef struct packed {
    logic       grey;
    logic       neg;
    logic [7:0] base;
    logic [7:0] chroma;
    logic [7:0] brightness;
    lane_t      sat_lane;
    lane_t      hue_lane;
  } stage_t;

  // The quotient always fits in 8 bits here, so the upper dividend byte is
  // already below the divisor and serves as the first partial remainder.
  function automatic lane_t lane_init(logic [15:0] num);
    lane_t l;
    l.rem = num[15:8];
    l.low = num[7:0];
    l.quo = 8'd0;
    return l;
  endfunction

  function automatic lane_t lane_step(lane_t l, logic [7:0] d);
    logic [8:0] t;
    lane_t      n;
    t     = {l.rem, l.low[7]};
    n.low = {l.low[6:0], 1'b0};
    if (t >= {1'b0, d}) begin
      n.rem = 8'(t - {1'b0, d});
      n.quo = {l.quo[6:0], 1'b1};
    end else begin
      n.rem = t[7:0];
      n.quo = {l.quo[6:0], 1'b0};
    end
    return n;
  endfunction

endpackage

@@ design/rhsv_front.sv @@
module rhsv_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pix_valid,
  output logic                   pix_stall,
  input  rhsv_pkg::pix_t         pix,
  input  rhsv_pkg::fifo_stat_t   stat,
  output logic                   push,
  output rhsv_pkg::work_t        work
);

  logic            valid;
  logic            advance;
  logic [7:0]      hi;
  logic [7:0]      lo;
  logic [7:0]      chroma;
  logic [8:0]      diff;
  logic [7:0]      mag;
  logic [7:0]      base;
  rhsv_pkg::work_t work_next;

  assign advance   = !valid || !stat.full;
  assign pix_stall = !advance;
  assign push      = valid && !stat.full;

  always_comb begin
    hi = (pix.red > pix.green) ? pix.red : pix.green;
    if (pix.blue > hi) begin
      hi = pix.blue;
    end
    lo = (pix.red < pix.green) ? pix.red : pix.green;
    if (pix.blue < lo) begin
      lo = pix.blue;
    end
    chroma = hi - lo;

    // Red wins ties for the largest channel, then green.
    if (hi == pix.red) begin
      base = rhsv_pkg::BASE_RED;
      diff = {1'b0, pix.green} - {1'b0, pix.blue};
    end else if (hi == pix.green) begin
      base = rhsv_pkg::BASE_GREEN;
      diff = {1'b0, pix.blue} - {1'b0, pix.red};
    end else begin
      base = rhsv_pkg::BASE_BLUE;
      diff = {1'b0, pix.red} - {1'b0, pix.green};
    end
    mag = diff[8] ? 8'(-diff) : diff[7:0];

    work_next.grey       = (chroma == 8'd0);
    work_next.neg        = diff[8];
    work_next.base       = base;
    work_next.chroma     = chroma;
    work_next.brightness = hi;
    work_next.sat_num    = 16'(rhsv_pkg::SAT_SCALE * {8'd0, chroma});
    work_next.hue_num    = 16'(rhsv_pkg::HUE_STEP * {8'd0, mag});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pix_valid) begin
      work <= work_next;
    end
  end

endmodule

@@ design/rhsv_fifo.sv @@
module rhsv_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rhsv_pkg::work_t       wr_data,
  input  logic                  pop,
  output rhsv_pkg::work_t       head,
  output rhsv_pkg::fifo_stat_t  stat
);

  rhsv_pkg::work_t                mem [rhsv_pkg::FIFO_DEPTH];
  logic [rhsv_pkg::PTR_W-1:0]     wr_ptr;
  logic [rhsv_pkg::PTR_W-1:0]     rd_ptr;
  logic [rhsv_pkg::CNT_W-1:0]     count;

  assign stat.full  = (count == rhsv_pkg::CNT_W'(rhsv_pkg::FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + rhsv_pkg::PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + rhsv_pkg::PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + rhsv_pkg::CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - rhsv_pkg::CNT_W'(1);
      end
    end
  end

endmodule

@@ design/rhsv_back.sv @@
module rhsv_back (
  input  logic                  clk,
  input  logic                  rst,
  input  rhsv_pkg::fifo_stat_t  stat,
  input  rhsv_pkg::work_t       head,
  output logic                  pop,
  output logic                  hsv_valid,
  input  logic                  hsv_stall,
  output rhsv_pkg::hsv_t        hsv
);

  localparam int N = rhsv_pkg::DIV_STAGES;

  logic                 move;
  logic                 vld     [N];
  rhsv_pkg::stage_t     stg     [N];
  rhsv_pkg::stage_t     stg_in  [N];
  rhsv_pkg::stage_t     stg_next[N];
  rhsv_pkg::hsv_t       hsv_next;
  logic [7:0]           q_hue;
  logic [7:0]           off;

  // The whole divider pipeline advances together whenever the output
  // register is free or being emptied.
  assign move = !hsv_valid || !hsv_stall;
  assign pop  = move && !stat.empty;

  always_comb begin
    stg_in[0].grey       = head.grey;
    stg_in[0].neg        = head.neg;
    stg_in[0].base       = head.base;
    stg_in[0].chroma     = head.chroma;
    stg_in[0].brightness = head.brightness;
    stg_in[0].sat_lane   = rhsv_pkg::lane_init(head.sat_num);
    stg_in[0].hue_lane   = rhsv_pkg::lane_init(head.hue_num);
    for (int i = 1; i < N; i++) begin
      stg_in[i] = stg[i-1];
    end
    // Each stage retires one quotient bit of both divisions.
    for (int i = 0; i < N; i++) begin
      stg_next[i]          = stg_in[i];
      stg_next[i].sat_lane = rhsv_pkg::lane_step(stg_in[i].sat_lane,
                                                 stg_in[i].brightness);
      stg_next[i].hue_lane = rhsv_pkg::lane_step(stg_in[i].hue_lane,
                                                 stg_in[i].chroma);
    end
  end

  always_comb begin
    q_hue = stg[N-1].hue_lane.quo;
    off   = stg[N-1].neg ? 8'(-q_hue) : q_hue;
    hsv_next.brightness = stg[N-1].brightness;
    if (stg[N-1].grey) begin
      hsv_next.hue        = 8'd0;
      hsv_next.saturation = 8'd0;
    end else begin
      hsv_next.hue        = stg[N-1].base + off;
      hsv_next.saturation = stg[N-1].sat_lane.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        vld[i] <= 1'b0;
      end
      hsv_valid <= 1'b0;
    end else if (move) begin
      vld[0] <= !stat.empty;
      for (int i = 1; i < N; i++) begin
        vld[i] <= vld[i-1];
      end
      hsv_valid <= vld[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      for (int i = 0; i < N; i++) begin
        stg[i] <= stg_next[i];
      end
      if (vld[N-1]) begin
        hsv <= hsv_next;
      end
    end
  end

endmodule

@@ design/rgb_to_hsv_byte.sv @@
// A pixel passes the front register, queue, divider stages and output register.
// Throughput: one pixel per cycle unless stalled; the 8-stage restoring divider
// pipeline in the back part retires one quotient bit of both divisions per stage.
// A 4-entry queue between front and back absorbs output stalls.
// Reset (synchronous, active high) empties the front register, queue and pipeline.
module rgb_to_hsv_byte (
  input  logic            clk,
  input  logic            rst,
  input  logic            pix_valid,
  output logic            pix_stall,
  input  rhsv_pkg::pix_t  pix,
  output logic            hsv_valid,
  input  logic            hsv_stall,
  output rhsv_pkg::hsv_t  hsv
);

  rhsv_pkg::fifo_stat_t stat;
  rhsv_pkg::work_t      work;
  rhsv_pkg::work_t      head;
  logic                 push;
  logic                 pop;

  rhsv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .stat      (stat),
    .push      (push),
    .work      (work)
  );

  rhsv_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (work),
    .pop     (pop),
    .head    (head),
    .stat    (stat)
  );

  rhsv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .stat      (stat),
    .head      (head),
    .pop       (pop),
    .hsv_valid (hsv_valid),
    .hsv_stall (hsv_stall),
    .hsv       (hsv)
  );

endmodule

@@ design/rhsv_check.sv @@
`include "rgb_to_hsv_byte_defines.svh"

module rhsv_check (
  input logic            clk,
  input logic            rst,
  input logic            hsv_valid,
  input logic            hsv_stall,
  input rhsv_pkg::hsv_t  hsv
);

  // A black pixel carries no saturation.
  `RHSV_ASSERT_SAME(a_black_no_sat, clk, rst, hsv_valid && (hsv.brightness == 8'd0), hsv.saturation == 8'd0)

  // An unsaturated (grey) pixel carries no hue.
  `RHSV_ASSERT_SAME(a_grey_no_hue, clk, rst, hsv_valid && (hsv.saturation == 8'd0), hsv.hue == 8'd0)

  // Reset leaves no result beat pending.
  `RHSV_ASSERT_NEXT(a_reset_empty, clk, rst, !hsv_valid)

  // A stalled result beat holds until taken.
  `RHSV_ASSERT_NEXT(a_out_hold, clk, !rst && hsv_valid && hsv_stall, rst || (hsv_valid && $stable(hsv)))

endmodule

bind rgb_to_hsv_byte rhsv_check u_check (.*);
